[sv/mrg_pkg.sv]
// ---------------------------------------------------------------------------
// mrg_pkg
// Shared types, constants and helpers of the combined recursive uniform
// generator: moduli, multipliers, request codes and sequencer states.
// ---------------------------------------------------------------------------
package mrg_pkg;

  // moduli of the two recurrences and 2^32 mod m for the folding steps
  localparam logic [31:0] MOD1  = 32'd4294967087;
  localparam logic [31:0] MOD2  = 32'd4294944443;
  localparam logic [14:0] FOLD1 = 15'd209;
  localparam logic [14:0] FOLD2 = 15'd22853;

  localparam logic [20:0] MUL12 = 21'd1403580;
  localparam logic [20:0] MUL13 = 21'd810728;
  localparam logic [20:0] MUL21 = 21'd527612;
  localparam logic [20:0] MUL23 = 21'd1370589;

  localparam logic [16:0] LCG_MUL = 17'd69069;
  localparam int unsigned SEED_ROUNDS_DEF = 50;

  // request codes
  localparam logic [1:0] ACT_NEXT = 2'd0;
  localparam logic [1:0] ACT_SEED = 2'd1;
  localparam logic [1:0] ACT_LOAD = 2'd2;

  localparam logic [2:0] LAST_WORD = 3'd5;
  localparam logic [2:0] FIRST_SECOND_WORD = 3'd3;

  // products of one next-sample step, in issue order
  typedef enum logic [1:0] {
    MM_A12,
    MM_A13,
    MM_A21,
    MM_A23
  } mm_op_t;

  typedef struct packed {
    logic   start;
    mm_op_t op;
  } mm_req_t;

  typedef struct packed {
    logic done;
  } mm_rsp_t;

  typedef struct packed {
    logic       word_valid;
    logic [2:0] idx;
  } lcg_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_COMBINE,
    ST_SEED,
    ST_FIX,
    ST_DONE
  } state_t;

  function automatic logic [20:0] mul_of(mm_op_t op);
    logic [20:0] k;
    case (op)
      MM_A12:  k = MUL12;
      MM_A13:  k = MUL13;
      MM_A21:  k = MUL21;
      MM_A23:  k = MUL23;
      default: k = MUL12;
    endcase
    return k;
  endfunction

  // (a - b) mod m for a, b below m; the 32-bit wrap is exact since the result is below m
  function automatic logic [31:0] mod_sub(logic [31:0] a, logic [31:0] b, logic [31:0] m);
    logic [31:0] r;
    if (a >= b) begin
      r = a - b;
    end else begin
      r = a + m - b;
    end
    return r;
  endfunction

endpackage

[sv/mrg_mulmod.sv]
// ---------------------------------------------------------------------------
// mrg_mulmod
// Shared constant multiply and modular reduce unit: (k * x) mod m, with
// 2^32 folded back twice and one final compare and subtract, each step registered.
// ---------------------------------------------------------------------------
module mrg_mulmod (
  input  logic             clk,
  input  logic             rst_n,
  input  mrg_pkg::mm_req_t req,
  input  logic [31:0]      x,
  output mrg_pkg::mm_rsp_t rsp,
  output logic [31:0]      res
);

  logic [52:0] prod_r, prod_nxt;
  logic [36:0] fold1_r, fold1_nxt;
  logic [32:0] fold2_r, fold2_nxt;
  logic [31:0] res_r, res_nxt;
  logic        second_r;
  logic [2:0]  stage_r;
  logic        done_r;
  logic [14:0] c_sel;
  logic [31:0] m_sel;

  assign c_sel = second_r ? mrg_pkg::FOLD2 : mrg_pkg::FOLD1;
  assign m_sel = second_r ? mrg_pkg::MOD2 : mrg_pkg::MOD1;

  always_comb begin
    prod_nxt  = 53'(mrg_pkg::mul_of(req.op)) * 53'(x);
    fold1_nxt = 37'(prod_r[52:32]) * 37'(c_sel) + 37'(prod_r[31:0]);
    fold2_nxt = 33'(fold1_r[36:32]) * 33'(c_sel) + 33'(fold1_r[31:0]);
    // fold2 stays below twice the modulus
    if (fold2_r >= {1'b0, m_sel}) begin
      res_nxt = 32'(fold2_r - {1'b0, m_sel});
    end else begin
      res_nxt = fold2_r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '0;
      done_r  <= 1'b0;
    end else begin
      stage_r <= {stage_r[1:0], req.start};
      done_r  <= stage_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      prod_r   <= prod_nxt;
      second_r <= (req.op == mrg_pkg::MM_A21) || (req.op == mrg_pkg::MM_A23);
    end
    if (stage_r[0]) begin
      fold1_r <= fold1_nxt;
    end
    if (stage_r[1]) begin
      fold2_r <= fold2_nxt;
    end
    if (stage_r[2]) begin
      res_r <= res_nxt;
    end
  end

  assign rsp.done = done_r;
  assign res      = res_r;

endmodule

[sv/mrg_lcg.sv]
// ---------------------------------------------------------------------------
// mrg_lcg
// Seed expander: 32-bit wrapping congruential step s = 69069*s + 1, one step
// per cycle, presenting a word after every SEED_ROUNDS steps, six words.
// ---------------------------------------------------------------------------
module mrg_lcg #(
  parameter int unsigned SEED_ROUNDS = mrg_pkg::SEED_ROUNDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        seed,
  output mrg_pkg::lcg_stat_t stat,
  output logic [31:0]        word
);

  localparam int unsigned RW = $clog2(SEED_ROUNDS + 1);

  logic [31:0]   s_r, s_nxt;
  logic [RW-1:0] round_r;
  logic [2:0]    idx_r;
  logic [2:0]    widx_r;
  logic          busy_r;
  logic          word_v_r;
  logic          round_last;

  assign s_nxt      = s_r * 32'(mrg_pkg::LCG_MUL) + 32'd1;
  assign round_last = (round_r == RW'(SEED_ROUNDS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      word_v_r <= 1'b0;
      round_r  <= '0;
      idx_r    <= '0;
    end else begin
      word_v_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        round_r <= '0;
        idx_r   <= '0;
      end else if (busy_r) begin
        if (round_last) begin
          round_r  <= '0;
          word_v_r <= 1'b1;
          idx_r    <= idx_r + 3'd1;
          if (idx_r == mrg_pkg::LAST_WORD) begin
            busy_r <= 1'b0;
          end
        end else begin
          round_r <= round_r + RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s_r <= seed;
    end else if (busy_r) begin
      s_r <= s_nxt;
    end
    if (busy_r && round_last) begin
      widx_r <= idx_r;
    end
  end

  // s_r holds the finished word in the cycle word_valid is up
  assign stat.word_valid = word_v_r;
  assign stat.idx        = widx_r;
  assign word            = s_r;

endmodule

[sv/mrg32k3a_uniform_generator_unit.sv]
// ---------------------------------------------------------------------------
// mrg32k3a_uniform_generator_unit
// Combined multiple recursive uniform generator with next, reseed and load
// requests; one result per request.
// ---------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  in       | in_valid / in_ready | in_action, in_seed, in_state_word_0..5
//  out      | out_valid/out_ready | out_sample, out_status
//
// a next request runs four products through the shared multiply-reduce unit,
// one after the other, then a combine step
// a reseed runs the seed expander, one congruential step per cycle
// a load or unused code needs no steps; state is reset to {1,0,0} per component
// one request at a time; a new one is taken while the last result waits
// ---------------------------------------------------------------------------
module mrg32k3a_uniform_generator_unit #(
  parameter int unsigned SEED_ROUNDS = mrg_pkg::SEED_ROUNDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_seed,
  input  logic [31:0] in_state_word_0,
  input  logic [31:0] in_state_word_1,
  input  logic [31:0] in_state_word_2,
  input  logic [31:0] in_state_word_3,
  input  logic [31:0] in_state_word_4,
  input  logic [31:0] in_state_word_5,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_sample,
  output logic        out_status
);

  mrg_pkg::state_t    state_r, state_nxt;
  mrg_pkg::mm_op_t    step_r, step_nxt;
  logic [31:0]        x1_r [3];
  logic [31:0]        x1_nxt [3];
  logic [31:0]        x2_r [3];
  logic [31:0]        x2_nxt [3];
  logic [31:0]        acc_r, acc_nxt;
  logic [31:0]        p1_r, p1_nxt;
  logic [31:0]        p2_r, p2_nxt;
  logic [31:0]        res_sample_r, res_sample_nxt;
  logic               res_status_r, res_status_nxt;
  logic               out_valid_r;
  logic [31:0]        out_sample_r;
  logic               out_status_r;
  logic               out_load;
  logic               load_ok;
  mrg_pkg::mm_req_t   mm_req;
  mrg_pkg::mm_rsp_t   mm_rsp;
  logic [31:0]        mm_x;
  logic [31:0]        mm_res;
  logic               lcg_start;
  mrg_pkg::lcg_stat_t lcg_stat;
  logic [31:0]        lcg_word;
  logic [2:0]         sec_idx;

  mrg_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .x     (mm_x),
    .rsp   (mm_rsp),
    .res   (mm_res)
  );

  mrg_lcg #(
    .SEED_ROUNDS (SEED_ROUNDS)
  ) u_lcg (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lcg_start),
    .seed  (in_seed),
    .stat  (lcg_stat),
    .word  (lcg_word)
  );

  assign in_ready = (state_r == mrg_pkg::ST_IDLE);
  assign out_load = (state_r == mrg_pkg::ST_DONE) && (!out_valid_r || out_ready);
  assign sec_idx  = lcg_stat.idx - mrg_pkg::FIRST_SECOND_WORD;

  assign load_ok = (in_state_word_0 < mrg_pkg::MOD1) && (in_state_word_1 < mrg_pkg::MOD1)
                && (in_state_word_2 < mrg_pkg::MOD1) && (in_state_word_3 < mrg_pkg::MOD2)
                && (in_state_word_4 < mrg_pkg::MOD2) && (in_state_word_5 < mrg_pkg::MOD2)
                && ((in_state_word_0 | in_state_word_1 | in_state_word_2) != 32'd0)
                && ((in_state_word_3 | in_state_word_4 | in_state_word_5) != 32'd0);

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    x1_nxt         = x1_r;
    x2_nxt         = x2_r;
    acc_nxt        = acc_r;
    p1_nxt         = p1_r;
    p2_nxt         = p2_r;
    res_sample_nxt = res_sample_r;
    res_status_nxt = res_status_r;
    mm_req.start   = 1'b0;
    mm_req.op      = step_r;
    mm_x           = 32'd0;
    lcg_start      = 1'b0;

    case (state_r)
      mrg_pkg::ST_IDLE: begin
        if (in_valid) begin
          res_sample_nxt = 32'd0;
          res_status_nxt = 1'b0;
          state_nxt      = mrg_pkg::ST_DONE;
          case (in_action)
            mrg_pkg::ACT_NEXT: begin
              step_nxt  = mrg_pkg::MM_A12;
              state_nxt = mrg_pkg::ST_ISSUE;
            end
            mrg_pkg::ACT_SEED: begin
              lcg_start = 1'b1;
              state_nxt = mrg_pkg::ST_SEED;
            end
            mrg_pkg::ACT_LOAD: begin
              if (load_ok) begin
                x1_nxt[0] = in_state_word_0;
                x1_nxt[1] = in_state_word_1;
                x1_nxt[2] = in_state_word_2;
                x2_nxt[0] = in_state_word_3;
                x2_nxt[1] = in_state_word_4;
                x2_nxt[2] = in_state_word_5;
              end else begin
                res_status_nxt = 1'b1;
              end
            end
            default: begin
              res_status_nxt = 1'b0;
            end
          endcase
        end
      end

      mrg_pkg::ST_ISSUE: begin
        mm_req.start = 1'b1;
        case (step_r)
          mrg_pkg::MM_A12: mm_x = x1_r[1];
          mrg_pkg::MM_A13: mm_x = x1_r[0];
          mrg_pkg::MM_A21: mm_x = x2_r[2];
          mrg_pkg::MM_A23: mm_x = x2_r[0];
          default:         mm_x = x1_r[1];
        endcase
        state_nxt = mrg_pkg::ST_WAIT;
      end

      mrg_pkg::ST_WAIT: begin
        if (mm_rsp.done) begin
          state_nxt = mrg_pkg::ST_ISSUE;
          case (step_r)
            mrg_pkg::MM_A12: begin
              acc_nxt  = mm_res;
              step_nxt = mrg_pkg::MM_A13;
            end
            mrg_pkg::MM_A13: begin
              p1_nxt   = mrg_pkg::mod_sub(acc_r, mm_res, mrg_pkg::MOD1);
              step_nxt = mrg_pkg::MM_A21;
            end
            mrg_pkg::MM_A21: begin
              acc_nxt  = mm_res;
              step_nxt = mrg_pkg::MM_A23;
            end
            mrg_pkg::MM_A23: begin
              p2_nxt    = mrg_pkg::mod_sub(acc_r, mm_res, mrg_pkg::MOD2);
              state_nxt = mrg_pkg::ST_COMBINE;
            end
            default: begin
              state_nxt = mrg_pkg::ST_IDLE;
            end
          endcase
        end
      end

      mrg_pkg::ST_COMBINE: begin
        x1_nxt[0] = x1_r[1];
        x1_nxt[1] = x1_r[2];
        x1_nxt[2] = p1_r;
        x2_nxt[0] = x2_r[1];
        x2_nxt[1] = x2_r[2];
        x2_nxt[2] = p2_r;
        // equal components give m1, not zero
        if (p1_r > p2_r) begin
          res_sample_nxt = p1_r - p2_r;
        end else begin
          res_sample_nxt = p1_r + mrg_pkg::MOD1 - p2_r;
        end
        state_nxt = mrg_pkg::ST_DONE;
      end

      mrg_pkg::ST_SEED: begin
        if (lcg_stat.word_valid) begin
          if (lcg_stat.idx < mrg_pkg::FIRST_SECOND_WORD) begin
            x1_nxt[lcg_stat.idx[1:0]] = (lcg_word >= mrg_pkg::MOD1) ? 32'd0 : lcg_word;
          end else begin
            x2_nxt[sec_idx[1:0]] = (lcg_word >= mrg_pkg::MOD2) ? 32'd0 : lcg_word;
          end
          if (lcg_stat.idx == mrg_pkg::LAST_WORD) begin
            state_nxt = mrg_pkg::ST_FIX;
          end
        end
      end

      mrg_pkg::ST_FIX: begin
        if ((x1_r[0] | x1_r[1] | x1_r[2]) == 32'd0) begin
          x1_nxt[0] = 32'd1;
        end
        if ((x2_r[0] | x2_r[1] | x2_r[2]) == 32'd0) begin
          x2_nxt[0] = 32'd1;
        end
        state_nxt = mrg_pkg::ST_DONE;
      end

      mrg_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = mrg_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = mrg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mrg_pkg::ST_IDLE;
      step_r      <= mrg_pkg::MM_A12;
      x1_r[0]     <= 32'd1;
      x1_r[1]     <= 32'd0;
      x1_r[2]     <= 32'd0;
      x2_r[0]     <= 32'd1;
      x2_r[1]     <= 32'd0;
      x2_r[2]     <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      x1_r    <= x1_nxt;
      x2_r    <= x2_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r        <= acc_nxt;
    p1_r         <= p1_nxt;
    p2_r         <= p2_nxt;
    res_sample_r <= res_sample_nxt;
    res_status_r <= res_status_nxt;
    if (out_load) begin
      out_sample_r <= res_sample_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_status = out_status_r;

endmodule

[sv/mrg_checker.sv]
// ---------------------------------------------------------------------------
// mrg_checker
// Port-level checks of the uniform generator, bound to the top level.
// ---------------------------------------------------------------------------
module mrg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_sample,
  input logic        out_status
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_status))
    else $error("stalled result changed");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  // a rejected load carries no sample
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_sample == 32'd0)
    else $error("rejected load with nonzero sample");

  a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sample <= mrg_pkg::MOD1)
    else $error("sample above m1");

endmodule

bind mrg32k3a_uniform_generator_unit mrg_checker u_mrg_checker (.*);

[verif/mrg32k3a_uniform_generator_unit_test.sv]
// ---------------------------------------------------------------------------
// mrg32k3a_uniform_generator_unit_test
// Drives next, reseed, load and unused requests into the combined recursive
// generator with random idling on both channels. A scoreboard keeps its own
// copy of both recurrences and checks every sample and status in order.
// ---------------------------------------------------------------------------
module mrg32k3a_uniform_generator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam longint unsigned M1 = mrg_pkg::MOD1;
  localparam longint unsigned M2 = mrg_pkg::MOD2;
  localparam int unsigned RANDOM_REQUESTS = 650;

  typedef logic [5:0][31:0] state_words_t;

  typedef struct packed {
    logic [31:0] sample;
    logic        status;
  } gen_result_t;

  class uniform_scoreboard;
    longint unsigned first_words[3];
    longint unsigned second_words[3];
    gen_result_t     pending_results[$];
    int unsigned     error_count;

    function new();
      first_words  = '{64'd1, 64'd0, 64'd0};
      second_words = '{64'd1, 64'd0, 64'd0};
      error_count  = 0;
    endfunction

    // (ka*xa - kb*xb) mod m, operands already below m
    static function longint unsigned recur_term(longint unsigned ka, longint unsigned xa,
                                                longint unsigned kb, longint unsigned xb,
                                                longint unsigned m);
      longint unsigned t;
      longint unsigned u;
      t = (ka * xa) % m;
      u = (kb * xb) % m;
      return (t >= u) ? (t - u) : (t + m - u);
    endfunction

    static function bit word_in_range(longint unsigned w[6], int i);
      return (i < 3) ? (w[i] < M1) : (w[i] < M2);
    endfunction

    function void note_request(logic [1:0] action, logic [31:0] seed, state_words_t words);
      gen_result_t     r;
      longint unsigned p1;
      longint unsigned p2;
      longint unsigned w[6];
      logic [31:0]     s;
      bit              ok;
      r = '0;
      case (action)
        mrg_pkg::ACT_NEXT: begin
          p1 = recur_term(mrg_pkg::MUL12, first_words[1], mrg_pkg::MUL13, first_words[0], M1);
          p2 = recur_term(mrg_pkg::MUL21, second_words[2], mrg_pkg::MUL23, second_words[0], M2);
          first_words  = '{first_words[1], first_words[2], p1};
          second_words = '{second_words[1], second_words[2], p2};
          r.sample = 32'((p1 > p2) ? (p1 - p2) : (p1 + M1 - p2));
        end
        mrg_pkg::ACT_SEED: begin
          s = seed;
          for (int i = 0; i < 6; i++) begin
            for (int j = 0; j < mrg_pkg::SEED_ROUNDS_DEF; j++) begin
              s = s * 32'(mrg_pkg::LCG_MUL) + 32'd1;
            end
            w[i] = s;
          end
          for (int i = 0; i < 6; i++) begin
            if (!word_in_range(w, i)) w[i] = 0;
          end
          if (w[0] == 0 && w[1] == 0 && w[2] == 0) w[0] = 1;
          if (w[3] == 0 && w[4] == 0 && w[5] == 0) w[3] = 1;
          first_words  = '{w[0], w[1], w[2]};
          second_words = '{w[3], w[4], w[5]};
        end
        mrg_pkg::ACT_LOAD: begin
          ok = 1'b1;
          for (int i = 0; i < 6; i++) begin
            w[i] = words[i];
            if (!word_in_range(w, i)) ok = 1'b0;
          end
          if (w[0] == 0 && w[1] == 0 && w[2] == 0) ok = 1'b0;
          if (w[3] == 0 && w[4] == 0 && w[5] == 0) ok = 1'b0;
          if (ok) begin
            first_words  = '{w[0], w[1], w[2]};
            second_words = '{w[3], w[4], w[5]};
          end else begin
            r.status = 1'b1;
          end
        end
        default: ;
      endcase
      pending_results = {pending_results, r};
    endfunction

    function void check_result(logic [31:0] sample, logic status);
      gen_result_t e;
      if (pending_results.size() == 0) begin
        $error("result with no request pending: sample %0d status %0d", sample, status);
        error_count++;
        return;
      end
      e = pending_results.pop_front();
      if (sample !== e.sample) begin
        $error("out_sample: expected %0d, got %0d", e.sample, sample);
        error_count++;
      end
      if (status !== e.status) begin
        $error("out_status: expected %0d, got %0d", e.status, status);
        error_count++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_action = mrg_pkg::ACT_NEXT;
  logic [31:0] in_seed = '0;
  logic [31:0] in_state_word_0 = '0;
  logic [31:0] in_state_word_1 = '0;
  logic [31:0] in_state_word_2 = '0;
  logic [31:0] in_state_word_3 = '0;
  logic [31:0] in_state_word_4 = '0;
  logic [31:0] in_state_word_5 = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_sample;
  logic        out_status;

  bit no_idle = 1'b0;
  uniform_scoreboard sb = new();

  mrg32k3a_uniform_generator_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_seed         (in_seed),
    .in_state_word_0 (in_state_word_0),
    .in_state_word_1 (in_state_word_1),
    .in_state_word_2 (in_state_word_2),
    .in_state_word_3 (in_state_word_3),
    .in_state_word_4 (in_state_word_4),
    .in_state_word_5 (in_state_word_5),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sample      (out_sample),
    .out_status      (out_status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      sb.note_request(in_action, in_seed,
                      {in_state_word_5, in_state_word_4, in_state_word_3,
                       in_state_word_2, in_state_word_1, in_state_word_0});
    end
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_sample, out_status);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // mostly in range, some at or past the modulus, some zero
  function automatic logic [31:0] pick_word(longint unsigned m);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 32'(longint'($urandom) % m);
    if (r < 80) return 32'(m - 1 - $urandom_range(0, 3));
    if (r < 86) return 32'(m + (longint'($urandom) % (64'h1_0000_0000 - m)));
    if (r < 92) return '0;
    return $urandom;
  endfunction

  function automatic state_words_t words_of(logic [31:0] a0, logic [31:0] a1, logic [31:0] a2,
                                            logic [31:0] b0, logic [31:0] b1, logic [31:0] b2);
    return {b2, b1, b0, a2, a1, a0};
  endfunction

  task automatic send_request(logic [1:0] action, logic [31:0] seed, state_words_t words);
    int gap;
    in_valid        <= 1'b1;
    in_action       <= action;
    in_seed         <= seed;
    in_state_word_0 <= words[0];
    in_state_word_1 <= words[1];
    in_state_word_2 <= words[2];
    in_state_word_3 <= words[3];
    in_state_word_4 <= words[4];
    in_state_word_5 <= words[5];
    do @(posedge clk); while (!in_ready);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  // result side: random stalls, none while no_idle is set
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (no_idle) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
  end

  initial begin
    logic [1:0]   action;
    state_words_t words;
    int           r;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // from the reset state
    send_request(mrg_pkg::ACT_NEXT, '0, '0);
    send_request(mrg_pkg::ACT_NEXT, '0, '0);
    send_request(mrg_pkg::ACT_NEXT, '0, '0);
    send_request(ACT_UNUSED, '1, '1);
    // largest legal words
    send_request(mrg_pkg::ACT_LOAD, '0, words_of(32'(M1 - 1), 32'(M1 - 1), 32'(M1 - 1),
                                                32'(M2 - 1), 32'(M2 - 1), 32'(M2 - 1)));
    send_request(mrg_pkg::ACT_NEXT, '0, '0);
    send_request(mrg_pkg::ACT_NEXT, '0, '0);
    // words at or above their modulus are refused
    send_request(mrg_pkg::ACT_LOAD, '0, words_of(32'(M1), 1, 2, 3, 4, 5));
    send_request(mrg_pkg::ACT_LOAD, '0, words_of(1, 2, '1, 3, 4, 5));
    send_request(mrg_pkg::ACT_LOAD, '0, words_of(1, 2, 3, 32'(M2), 4, 5));
    send_request(mrg_pkg::ACT_LOAD, '0, words_of(1, 2, 3, 4, 5, 32'(M2 + 1)));
    // all-zero component refused
    send_request(mrg_pkg::ACT_LOAD, '0, words_of(0, 0, 0, 4, 5, 6));
    send_request(mrg_pkg::ACT_LOAD, '0, words_of(1, 2, 3, 0, 0, 0));
    // m2 is legal in the first component
    send_request(mrg_pkg::ACT_LOAD, '0, words_of(32'(M2), 0, 0, 1, 0, 0));
    send_request(mrg_pkg::ACT_NEXT, '0, '0);
    // both new words zero, so the sample reaches m1
    send_request(mrg_pkg::ACT_LOAD, '0, words_of(0, 0, 5, 0, 7, 0));
    send_request(mrg_pkg::ACT_NEXT, '0, '0);
    send_request(mrg_pkg::ACT_NEXT, '0, '0);
    send_request(mrg_pkg::ACT_SEED, '0, '0);
    send_request(mrg_pkg::ACT_NEXT, '0, '0);
    send_request(mrg_pkg::ACT_SEED, '1, '0);
    send_request(mrg_pkg::ACT_NEXT, '0, '0);
    send_request(ACT_UNUSED, '0, '0);
    send_request(mrg_pkg::ACT_NEXT, '0, '0);
    wait_drained();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (n % 160 == 159) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 60) action = mrg_pkg::ACT_NEXT;
      else if (r < 75) action = mrg_pkg::ACT_SEED;
      else if (r < 95) action = mrg_pkg::ACT_LOAD;
      else action = ACT_UNUSED;
      for (int i = 0; i < 6; i++) begin
        words[i] = pick_word((i < 3) ? M1 : M2);
      end
      r = $urandom_range(0, 19);
      if (r == 0) words[2:0] = '0;
      if (r == 1) words[5:3] = '0;
      send_request(action, $urandom, words);
    end

    no_idle = 1'b0;
    wait_drained();
    repeat (40) @(posedge clk);
    if (sb.error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[files.f]
sv/mrg_pkg.sv
sv/mrg_mulmod.sv
sv/mrg_lcg.sv
sv/mrg32k3a_uniform_generator_unit.sv
sv/mrg_checker.sv
verif/mrg32k3a_uniform_generator_unit_test.sv
